/* design/tqs_pkg.sv */
`timescale 1ns / 1ps

package tqs_pkg;

    // Amplitude format: signed, two integer bits, the rest fraction
    localparam int AMP_WIDTH      = 16;
    localparam int FRAC_BITS      = AMP_WIDTH - 2;
    localparam int RAND_WIDTH     = 17;
    localparam int RAND_FRAC_BITS = 16;
    localparam int INV_SQRT2_Q15  = 23170;   // 1/sqrt2 with 15 fraction bits
    localparam int K_FRAC_BITS    = 15;

    typedef logic signed [AMP_WIDTH-1:0] t_amp;

    localparam t_amp AMP_ONE  = t_amp'(2 ** FRAC_BITS);
    localparam t_amp AMP_ZERO = t_amp'(0);

    typedef enum logic [1:0] {
        OP_INIT     = 2'd0,
        OP_HADAMARD = 2'd1,
        OP_CNOT     = 2'd2,
        OP_MEASURE  = 2'd3
    } t_opcode;

    typedef struct packed {
        t_opcode                opcode;
        logic [RAND_WIDTH-1:0]  random_fraction;
    } t_in_item;

    typedef struct packed {
        t_amp        amp_00;
        t_amp        amp_01;
        t_amp        amp_10;
        t_amp        amp_11;
        logic        is_measured;
        logic [1:0]  outcome;
    } t_out_item;

endpackage

/* design/tqs_hmix.sv */
`timescale 1ns / 1ps

// Hadamard butterfly on one amplitude pair: (a+b)/sqrt2 and (a-b)/sqrt2,
// rounded half up and saturated.
module tqs_hmix
    import tqs_pkg::*;
(
    input  t_amp i_a,
    input  t_amp i_b,
    output t_amp o_sum,
    output t_amp o_diff
);

    localparam int SUM_W  = AMP_WIDTH + 1;
    localparam int PROD_W = SUM_W + K_FRAC_BITS + 1;

    localparam logic signed [PROD_W-1:0] K_S     = PROD_W'(INV_SQRT2_Q15);
    localparam logic signed [PROD_W-1:0] RND     = PROD_W'(2 ** (K_FRAC_BITS - 1));
    localparam logic signed [PROD_W-1:0] SAT_MAX = PROD_W'(2 ** (AMP_WIDTH - 1) - 1);
    localparam logic signed [PROD_W-1:0] SAT_MIN = -(PROD_W'(2 ** (AMP_WIDTH - 1)));

    function automatic t_amp mix_round(input logic signed [SUM_W-1:0] s);
        logic signed [PROD_W-1:0] p;
        logic signed [PROD_W-1:0] q;
        p = PROD_W'(s) * K_S;
        q = (p + RND) >>> K_FRAC_BITS;   // arithmetic shift = floor
        if (q > SAT_MAX) begin
            return t_amp'(SAT_MAX);
        end else if (q < SAT_MIN) begin
            return t_amp'(SAT_MIN);
        end
        return t_amp'(q);
    endfunction

    logic signed [SUM_W-1:0] w_sum;
    logic signed [SUM_W-1:0] w_diff;

    assign w_sum  = SUM_W'(i_a) + SUM_W'(i_b);
    assign w_diff = SUM_W'(i_a) - SUM_W'(i_b);

    assign o_sum  = mix_round(w_sum);
    assign o_diff = mix_round(w_diff);

endmodule

/* design/tqs_measure.sv */
`timescale 1ns / 1ps

// Outcome pick: squares the amplitudes, keeps a running sum and returns the
// first index whose sum reaches the random fraction, else 3.
module tqs_measure
    import tqs_pkg::*;
(
    input  t_amp                   i_amp [4],
    input  logic [RAND_WIDTH-1:0]  i_random_fraction,
    output logic [1:0]             o_picked
);

    localparam int FB2    = 2 * FRAC_BITS;
    localparam int LHS_SH = (FB2 >= RAND_FRAC_BITS) ? FB2 - RAND_FRAC_BITS : 0;
    localparam int RHS_SH = (FB2 >= RAND_FRAC_BITS) ? 0 : RAND_FRAC_BITS - FB2;
    localparam int SQ_W   = 2 * AMP_WIDTH;
    localparam int SUM_W  = SQ_W + 2;
    localparam int LHS_W  = RAND_WIDTH + LHS_SH;
    localparam int RHS_W  = SUM_W + RHS_SH;
    localparam int CMP_W  = (LHS_W > RHS_W) ? LHS_W : RHS_W;

    logic [AMP_WIDTH-1:0] w_mag [4];
    logic [SQ_W-1:0]      w_sq  [4];
    logic [SUM_W-1:0]     w_acc [4];
    logic [CMP_W-1:0]     w_lhs;
    logic [3:0]           w_hit;

    always_comb begin
        // magnitude of the most negative code reads correctly as unsigned
        for (int i = 0; i < 4; i++) begin
            w_mag[i] = i_amp[i][AMP_WIDTH-1] ? (~i_amp[i] + 1'b1) : i_amp[i];
            w_sq[i]  = SQ_W'(w_mag[i]) * SQ_W'(w_mag[i]);
        end
        w_acc[0] = SUM_W'(w_sq[0]);
        for (int i = 1; i < 4; i++) begin
            w_acc[i] = w_acc[i-1] + SUM_W'(w_sq[i]);
        end
        w_lhs = CMP_W'(i_random_fraction) << LHS_SH;
        for (int i = 0; i < 4; i++) begin
            w_hit[i] = (w_lhs <= (CMP_W'(w_acc[i]) << RHS_SH));
        end
    end

    always_comb begin
        priority if (w_hit[0]) begin
            o_picked = 2'd0;
        end else if (w_hit[1]) begin
            o_picked = 2'd1;
        end else if (w_hit[2]) begin
            o_picked = 2'd2;
        end else begin
            o_picked = 2'd3;
        end
    end

endmodule

/* design/two_qubit_state_sim_unit.sv */
`timescale 1ns / 1ps

// Channel   Direction  Handshake                     Payload
// in        input      i_in_valid / o_in_ready       i_in_item  (t_in_item)
// out       output     o_out_valid / i_out_ready     o_out_item (t_out_item)
//
// One item per cycle sustained while i_out_ready is high; an accepted item
// goes through the input register, then the state and result registers,
// before o_out_valid is raised.
// The gate logic (four constant multiplies, or four squares and a prefix sum)
// sits between the input register and the state/result registers.
// Synchronous active-low reset returns the state to |00>, clears the flag and
// outcome, and empties both registers.
// While the result waits on i_out_ready, one more item is held in the input
// register; o_in_ready falls only when both are full.
module two_qubit_state_sim_unit
    import tqs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    // input register
    logic      r_in_valid;
    t_in_item  r_in;

    // simulator state
    t_amp       r_amp [4];
    logic       r_measured;
    logic [1:0] r_outcome;

    // result register
    logic      r_out_valid;
    t_out_item r_out;

    t_amp       n_amp [4];
    logic       n_measured;
    logic [1:0] n_outcome;

    t_amp       w_h0, w_h2, w_h1, w_h3;
    logic [1:0] w_picked;
    logic       w_fire;

    // process the held item when the result slot is free or draining
    assign w_fire     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_fire;

    tqs_hmix u_hmix_02 (
        .i_a    (r_amp[0]),
        .i_b    (r_amp[2]),
        .o_sum  (w_h0),
        .o_diff (w_h2)
    );

    tqs_hmix u_hmix_13 (
        .i_a    (r_amp[1]),
        .i_b    (r_amp[3]),
        .o_sum  (w_h1),
        .o_diff (w_h3)
    );

    tqs_measure u_measure (
        .i_amp             (r_amp),
        .i_random_fraction (r_in.random_fraction),
        .o_picked          (w_picked)
    );

    always_comb begin
        n_amp      = r_amp;
        n_measured = r_measured;
        n_outcome  = r_outcome;
        unique case (r_in.opcode)
            OP_INIT: begin
                for (int i = 0; i < 4; i++) begin
                    n_amp[i] = AMP_ZERO;
                end
                n_amp[0]   = AMP_ONE;
                n_measured = 1'b0;
                n_outcome  = 2'd0;
            end
            OP_HADAMARD: begin
                n_amp[0]   = w_h0;
                n_amp[1]   = w_h1;
                n_amp[2]   = w_h2;
                n_amp[3]   = w_h3;
                n_measured = 1'b0;
            end
            OP_CNOT: begin
                n_amp[2]   = r_amp[3];
                n_amp[3]   = r_amp[2];
                n_measured = 1'b0;
            end
            OP_MEASURE: begin
                // collapse to the picked basis state
                for (int i = 0; i < 4; i++) begin
                    n_amp[i] = AMP_ZERO;
                end
                n_amp[w_picked] = AMP_ONE;
                n_measured      = 1'b1;
                n_outcome       = w_picked;
            end
            default: begin
                n_amp = r_amp;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_amp[0]    <= AMP_ONE;
            r_amp[1]    <= AMP_ZERO;
            r_amp[2]    <= AMP_ZERO;
            r_amp[3]    <= AMP_ZERO;
            r_measured  <= 1'b0;
            r_outcome   <= 2'd0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_fire) begin
                r_amp       <= n_amp;
                r_measured  <= n_measured;
                r_outcome   <= n_outcome;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
        if (w_fire) begin
            r_out.amp_00      <= n_amp[0];
            r_out.amp_01      <= n_amp[1];
            r_out.amp_10      <= n_amp[2];
            r_out.amp_11      <= n_amp[3];
            r_out.is_measured <= n_measured;
            r_out.outcome     <= n_outcome;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // a processed item always lands in the result register
    a_fire_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> o_out_valid)
        else $error("processed item did not reach the result register");

    // a waiting result reflects the current flag and outcome
    a_out_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.is_measured == r_measured)
                        && (o_out_item.outcome == r_outcome))
        else $error("result flag/outcome out of step with state");

    // measure leaves exactly one nonzero amplitude, at the outcome index
    a_measure_collapse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_in.opcode == OP_MEASURE) |=>
            $onehot({r_amp[3] != AMP_ZERO, r_amp[2] != AMP_ZERO,
                     r_amp[1] != AMP_ZERO, r_amp[0] != AMP_ZERO})
            && r_measured && (r_amp[r_outcome] == AMP_ONE))
        else $error("measure did not collapse the state");

    // init restores |00>
    a_init_basis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_in.opcode == OP_INIT) |=>
            (r_amp[0] == AMP_ONE) && (r_amp[1] == AMP_ZERO)
            && (r_amp[2] == AMP_ZERO) && (r_amp[3] == AMP_ZERO) && !r_measured)
        else $error("init did not restore the ground state");

endmodule

/* verif/tqs_state_checker.sv */
`timescale 1ns / 1ps

// Watches both channels of the state simulator, keeps its own copy of the
// two-qubit state, and checks each result item against the predicted one.
module tqs_state_checker
    import tqs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_item,
    output int        o_fail_count,
    output int        o_outstanding
);

    localparam longint AMP_HI = (longint'(1) <<< (AMP_WIDTH - 1)) - 1;
    localparam longint AMP_LO = -(longint'(1) <<< (AMP_WIDTH - 1));
    localparam longint unsigned SUM_CAP = 64'd1 << 62;
    localparam int SQ_FRAC = 2 * FRAC_BITS;

    t_amp        amp_state [4];
    logic        measured_state;
    logic [1:0]  outcome_state;
    t_out_item   expected_states [$];
    t_out_item   predicted;
    t_out_item   wanted;
    int          fails = 0;

    // round((a +/- b) / sqrt2), half up, saturated
    function automatic t_amp mix_pair(t_amp a, t_amp b, bit subtract);
        longint s;
        longint q;
        s = subtract ? (longint'(a) - longint'(b)) : (longint'(a) + longint'(b));
        q = (s * INV_SQRT2_Q15 + (longint'(1) <<< (K_FRAC_BITS - 1))) >>> K_FRAC_BITS;
        if (q > AMP_HI) q = AMP_HI;
        if (q < AMP_LO) q = AMP_LO;
        return t_amp'(q);
    endfunction

    task automatic load_basis(logic [1:0] idx);
        for (int i = 0; i < 4; i++) amp_state[i] = AMP_ZERO;
        amp_state[idx] = AMP_ONE;
    endtask

    task automatic apply_gate(input t_in_item it, output t_out_item res);
        t_amp              a0, a1, a2, a3;
        longint unsigned   lhs, acc, rhs, mag;
        logic [1:0]        picked;
        bit                found;
        a0 = amp_state[0];
        a1 = amp_state[1];
        a2 = amp_state[2];
        a3 = amp_state[3];
        case (it.opcode)
            OP_INIT: begin
                load_basis(2'd0);
                measured_state = 1'b0;
                outcome_state  = 2'd0;
            end
            OP_HADAMARD: begin
                amp_state[0] = mix_pair(a0, a2, 1'b0);
                amp_state[2] = mix_pair(a0, a2, 1'b1);
                amp_state[1] = mix_pair(a1, a3, 1'b0);
                amp_state[3] = mix_pair(a1, a3, 1'b1);
                measured_state = 1'b0;
            end
            OP_CNOT: begin
                amp_state[2] = a3;
                amp_state[3] = a2;
                measured_state = 1'b0;
            end
            default: begin
                // first index whose running sum of squares reaches the fraction
                picked = 2'd3;
                found  = 1'b0;
                acc    = 0;
                if (SQ_FRAC >= RAND_FRAC_BITS)
                    lhs = longint'(it.random_fraction) << (SQ_FRAC - RAND_FRAC_BITS);
                else
                    lhs = longint'(it.random_fraction);
                for (int i = 0; i < 4; i++) begin
                    mag = (amp_state[i] < 0) ? longint'(-longint'(amp_state[i]))
                                             : longint'(amp_state[i]);
                    acc = acc + mag * mag;
                    if (acc > SUM_CAP) acc = SUM_CAP;
                    rhs = (SQ_FRAC >= RAND_FRAC_BITS) ? acc
                                                      : (acc << (RAND_FRAC_BITS - SQ_FRAC));
                    if (!found && lhs <= rhs) begin
                        picked = 2'(i);
                        found  = 1'b1;
                    end
                end
                load_basis(picked);
                measured_state = 1'b1;
                outcome_state  = picked;
            end
        endcase
        res.amp_00      = amp_state[0];
        res.amp_01      = amp_state[1];
        res.amp_10      = amp_state[2];
        res.amp_11      = amp_state[3];
        res.is_measured = measured_state;
        res.outcome     = outcome_state;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            load_basis(2'd0);
            measured_state = 1'b0;
            outcome_state  = 2'd0;
            expected_states.delete();
        end else begin
            // drain before predicting: a result never belongs to this cycle's item
            if (i_out_valid && i_out_ready) begin
                if (expected_states.size() == 0) begin
                    $error("result item with nothing expected");
                    fails++;
                end else begin
                    wanted = expected_states.pop_front();
                    if (i_out_item.amp_00 !== wanted.amp_00) begin
                        $error("amp_00: expected %0d, got %0d", wanted.amp_00, i_out_item.amp_00);
                        fails++;
                    end
                    if (i_out_item.amp_01 !== wanted.amp_01) begin
                        $error("amp_01: expected %0d, got %0d", wanted.amp_01, i_out_item.amp_01);
                        fails++;
                    end
                    if (i_out_item.amp_10 !== wanted.amp_10) begin
                        $error("amp_10: expected %0d, got %0d", wanted.amp_10, i_out_item.amp_10);
                        fails++;
                    end
                    if (i_out_item.amp_11 !== wanted.amp_11) begin
                        $error("amp_11: expected %0d, got %0d", wanted.amp_11, i_out_item.amp_11);
                        fails++;
                    end
                    if (i_out_item.is_measured !== wanted.is_measured) begin
                        $error("is_measured: expected %0d, got %0d",
                               wanted.is_measured, i_out_item.is_measured);
                        fails++;
                    end
                    if (i_out_item.outcome !== wanted.outcome) begin
                        $error("outcome: expected %0d, got %0d",
                               wanted.outcome, i_out_item.outcome);
                        fails++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                apply_gate(i_in_item, predicted);
                expected_states.push_back(predicted);
            end
        end
        o_fail_count  <= fails;
        o_outstanding <= expected_states.size();
    end

endmodule

/* verif/tb_two_qubit_state_sim_unit.sv */
`timescale 1ns / 1ps

// Testbench top: drives gate items into the simulator, throttles the result
// side, and reports the verdict. Result checking lives in tqs_state_checker.
module tb_two_qubit_state_sim_unit;
    import tqs_pkg::*;

    localparam int ITEMS_PER_PHASE = 630;     // three phases, ~1900 items
    localparam int RX_HOLD_CYCLES  = 60;      // long back-pressure stretch
    localparam int TAIL_CYCLES     = 4;       // idle tail before the verdict
    localparam int CYCLE_LIMIT     = 400000;  // watchdog limit

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    t_in_item   in_item   = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    t_out_item  out_item;

    int         fail_count;
    int         outstanding;

    // Idle percentages. tx_idle_pct is only used by the stimulus process;
    // rx_idle_pct is read by the receiver process, so it is written with NBAs.
    int         tx_idle_pct = 0;
    int         rx_idle_pct = 0;
    int         items_sent  = 0;

    // Hold requests: the stimulus bumps hold_req, the receiver notices the
    // change and counts the stretch itself.
    int         hold_req  = 0;
    int         hold_seen = 0;
    int         hold_left = 0;

    int         cycle_count = 0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    two_qubit_state_sim_unit u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    tqs_state_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_item     (in_item),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_item    (out_item),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // Receiver: random stalls, plus a long hold whenever one is requested.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= RX_HOLD_CYCLES;
            out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[two_qubit_state_sim_unit] ERROR");
            $finish;
        end
    end

    // Offers one item, after a random idle gap, and returns at the edge
    // where it is taken. Valid stays up with a fixed payload until then.
    task automatic send_op(t_opcode op, logic [RAND_WIDTH-1:0] frac);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= t_in_item'{opcode: op, random_fraction: frac};
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    // Lowers valid and waits until every predicted result has come back.
    // The checker's count is registered, so the first look waits for a clock edge.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // Measurement fractions: full range, the legal 0..1.0 range, values hugging
    // the quarter points where running sums of squares land, and values near zero.
    function automatic logic [RAND_WIDTH-1:0] pick_fraction();
        int base;
        base = 0;
        case ($urandom_range(3))
            0: return RAND_WIDTH'($urandom_range((1 << RAND_WIDTH) - 1));
            1: return RAND_WIDTH'($urandom_range(1 << RAND_FRAC_BITS));
            2: begin
                base = $urandom_range(1, 4) << (RAND_FRAC_BITS - 2);
                return RAND_WIDTH'(base + $urandom_range(8) - 4);
            end
            default: return RAND_WIDTH'($urandom_range(8));
        endcase
    endfunction

    // Mostly a well-formed circuit: optional init, a few gates, a measure.
    // One in ten is a lone random item.
    task automatic run_circuit();
        int n_gates;
        if ($urandom_range(9) == 0) begin
            send_op(t_opcode'($urandom_range(3)),
                    RAND_WIDTH'($urandom_range((1 << RAND_WIDTH) - 1)));
        end else begin
            if ($urandom_range(9) < 3)
                send_op(OP_INIT, RAND_WIDTH'($urandom_range((1 << RAND_WIDTH) - 1)));
            n_gates = $urandom_range(1, 6);
            repeat (n_gates)
                send_op($urandom_range(1) ? OP_HADAMARD : OP_CNOT,
                        RAND_WIDTH'($urandom_range((1 << RAND_WIDTH) - 1)));
            send_op(OP_MEASURE, pick_fraction());
        end
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed ----
        // measure on |00>: zero fraction, exactly 1.0, just above 1.0, max
        send_op(OP_MEASURE, 17'd0);
        send_op(OP_MEASURE, 17'd65536);
        send_op(OP_MEASURE, 17'd65537);       // nothing reaches it -> index 3
        send_op(OP_MEASURE, 17'h1FFFF);       // on |11>, still index 3
        send_op(OP_INIT, 17'h1FFFF);
        // H on |00> gives two 11585 amplitudes; the first square sits just
        // below 0.5, so 32766 picks 0 while 32767 and 32768 pick 2
        send_op(OP_HADAMARD, 17'd0);
        send_op(OP_MEASURE, 17'd32768);
        send_op(OP_INIT, 17'd0);
        send_op(OP_HADAMARD, 17'd0);
        send_op(OP_MEASURE, 17'd32767);
        send_op(OP_INIT, 17'd0);
        send_op(OP_HADAMARD, 17'd0);
        send_op(OP_MEASURE, 17'd32766);
        // Bell-like state: rounded state sums to just under 1.0
        send_op(OP_INIT, 17'd0);
        send_op(OP_HADAMARD, 17'd0);
        send_op(OP_CNOT, 17'd0);
        send_op(OP_MEASURE, 17'd65536);
        send_op(OP_CNOT, 17'h1FFFF);
        send_op(OP_MEASURE, 17'd0);
        // H on |10> gives a negative amplitude (subtract path, half-up rounding)
        send_op(OP_INIT, 17'd0);
        send_op(OP_HADAMARD, 17'd0);
        send_op(OP_MEASURE, 17'd32768);       // collapses to |10>
        send_op(OP_HADAMARD, 17'd0);
        send_op(OP_HADAMARD, 17'd0);          // back near |10>, off by rounding
        send_op(OP_MEASURE, 17'd1);
        wait_drained();

        // ---- phase 1: sender idles a little, receiver a lot ----
        tx_idle_pct = 16;
        rx_idle_pct <= 88;
        items_sent  = 0;
        while (items_sent < ITEMS_PER_PHASE) run_circuit();
        wait_drained();                       // sender pause until all results are back

        // ---- phase 2: the other way round ----
        tx_idle_pct = 88;
        rx_idle_pct <= 16;
        items_sent  = 0;
        while (items_sent < ITEMS_PER_PHASE) run_circuit();
        wait_drained();

        // ---- phase 3: no idling, with one long receiver hold at the start
        // so the block fills and drops in_ready while items keep coming ----
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        hold_req    <= hold_req + 1;
        items_sent  = 0;
        while (items_sent < ITEMS_PER_PHASE) run_circuit();
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("[two_qubit_state_sim_unit] OK");
        end else begin
            $display("[two_qubit_state_sim_unit] ERROR");
        end
        $finish;
    end

endmodule
